/* hw/rtl/decimal_string_to_packed_decimal_assert.svh */
// Assertion macros for the decimal string to packed decimal block.
// Included by files that check their own logic; no other dependencies.
`ifndef DECIMAL_STRING_TO_PACKED_DECIMAL_ASSERT_SVH
`define DECIMAL_STRING_TO_PACKED_DECIMAL_ASSERT_SVH
`ifndef ASSERT_OFF
`define DSPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define DSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define DSPD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/dspd_pkg.sv */
// Shared types and constants of the decimal string to packed decimal block.
// No dependencies.
package dspd_pkg;

  localparam int MaxDigitsDefault = 14;
  localparam int QueueDepthDefault = 2;
  localparam int CoeffW = 48;
  localparam int ExpW = 8;
  localparam int CntW = 4;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [7:0] TagInteger = 8'h01;
  localparam logic [7:0] TagDecimal = 8'h02;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_SIGN  = 2'd1,
    KIND_DIGIT = 2'd2,
    KIND_POINT = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
    logic       neg;
    logic       last;
  } item_t;

endpackage

/* hw/rtl/decimal_string_to_packed_decimal.sv */
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   char_byte_i[7:0], is_last_i
// out      out_valid_o / out_ready_i coefficient_o[47:0], exponent_o[7:0], packed_word_o[63:0]
//
// One character beat a cycle sustained while the result is not stalled; a beat passes
// the front combinationally into the queue, then the back's registered multiply-by-ten-and-add.
// A last beat's result shows once the beat has left the queue and the back has registered it.
// Reset clears the accumulators and the queue; the first beat is a sign candidate.
// A stalled result blocks only a last beat at the queue head (and beats behind it); other beats flow.
// Top level of the decimal string to packed decimal block.
// Depends on dspd_pkg, dspd_front, dspd_fifo, dspd_back and the assertion header.
`include "decimal_string_to_packed_decimal_assert.svh"
module decimal_string_to_packed_decimal import dspd_pkg::*; #(
  parameter int MAX_DIGITS = MaxDigitsDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               char_byte_i,
  input  logic                     is_last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoeffW-1:0] coefficient_o,
  output logic signed [ExpW-1:0]   exponent_o,
  output logic [63:0]              packed_word_o
);

  logic  f_valid, f_ready, b_valid, b_ready;
  item_t f_item, b_item;

  dspd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .is_last_i   (is_last_i),
    .item_valid_o(f_valid),
    .item_ready_i(f_ready),
    .item_o      (f_item)
  );

  dspd_fifo #(
    .Depth(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_item_i (f_item),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_item_o (b_item)
  );

  dspd_back #(
    .MaxDigits(MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coefficient_o(coefficient_o),
    .exponent_o   (exponent_o),
    .packed_word_o(packed_word_o)
  );

  `DSPD_ASSERT_NEXT(a_last_pop_gives_result, clk_i, rst_ni, b_valid && b_ready && b_item.last, out_valid_o)
  `DSPD_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, out_valid_o && !out_ready_i && b_valid && b_item.last, !b_ready)
  `DSPD_ASSERT_IMPL(a_plain_beat_flows, clk_i, rst_ni, b_valid && !b_item.last, b_ready)

endmodule

/* hw/rtl/dspd_fifo.sv */
// Short queue of classified beats between front and back.
// Depends on dspd_pkg for the item type.
module dspd_fifo import dspd_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_item_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output item_t rd_item_o
);

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  item_t          mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           push, pop;

  assign wr_ready_o = (cnt_q != CW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

/* hw/rtl/dspd_front.sv */
// Front end: accepts character beats and classifies them.
// Depends on dspd_pkg for character codes and the item type.
module dspd_front import dspd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       is_last_i,
  output logic       item_valid_o,
  input  logic       item_ready_i,
  output item_t      item_o
);

  logic at_first_q, at_first_d;
  logic accept;
  logic [7:0] digit_off;

  assign in_ready_o   = item_ready_i;
  assign item_valid_o = in_valid_i;
  assign accept       = in_valid_i && item_ready_i;
  assign digit_off    = char_byte_i - CharZero;

  always_comb begin
    item_o.kind  = KIND_OTHER;
    item_o.digit = digit_off[3:0];
    item_o.neg   = (char_byte_i == CharMinus);
    item_o.last  = is_last_i;
    if (at_first_q && (char_byte_i == CharPlus || char_byte_i == CharMinus)) begin
      item_o.kind = KIND_SIGN;
    end else if (char_byte_i inside {[CharZero:CharNine]}) begin
      item_o.kind = KIND_DIGIT;
    end else if (char_byte_i == CharDot) begin
      item_o.kind = KIND_POINT;
    end
  end

  always_comb begin
    at_first_d = at_first_q;
    if (accept) begin
      at_first_d = is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_first_q <= 1'b1;
    end else begin
      at_first_q <= at_first_d;
    end
  end

endmodule

/* hw/rtl/dspd_back.sv */
// Back end: accumulates coefficient and exponent, holds the result beat.
// Depends on dspd_pkg for widths, tags and the item type.
module dspd_back import dspd_pkg::*; #(
  parameter int MaxDigits = MaxDigitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  output logic                     item_ready_o,
  input  item_t                    item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoeffW-1:0] coefficient_o,
  output logic signed [ExpW-1:0]   exponent_o,
  output logic [63:0]              packed_word_o
);

  logic [CoeffW-1:0]        coeff_q, coeff_d, coeff_n;
  logic signed [ExpW-1:0]   exp_q, exp_d, exp_n;
  logic [CntW-1:0]          cnt_q, cnt_d, cnt_n;
  logic                     point_q, point_d, point_n;
  logic                     neg_q, neg_d, neg_n;
  logic                     out_valid_q, out_valid_d;
  logic [CoeffW-1:0]        res_mag_q, res_mag_d;
  logic signed [ExpW-1:0]   res_exp_q, res_exp_d;
  logic                     res_neg_q, res_neg_d;
  logic                     pop;
  logic [CoeffW-1:0]        coef;

  assign item_ready_o = !item_i.last || !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  always_comb begin
    coeff_n = coeff_q;
    exp_n   = exp_q;
    cnt_n   = cnt_q;
    point_n = point_q;
    neg_n   = neg_q;
    case (item_i.kind)
      KIND_SIGN: begin
        neg_n = item_i.neg;
      end
      KIND_DIGIT: begin
        if (cnt_q != {CntW{1'b1}}) begin
          cnt_n = cnt_q + CntW'(1);
        end
        if (cnt_n <= CntW'(MaxDigits)) begin
          coeff_n = (coeff_q << 3) + (coeff_q << 1) + CoeffW'(item_i.digit);
          if (point_q && exp_q != -8'sd128) begin
            exp_n = exp_q - 8'sd1;
          end
        end else if (!point_q && exp_q != 8'sd127) begin
          exp_n = exp_q + 8'sd1;
        end
      end
      KIND_POINT: begin
        point_n = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    coeff_d     = coeff_q;
    exp_d       = exp_q;
    cnt_d       = cnt_q;
    point_d     = point_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_mag_d   = res_mag_q;
    res_exp_d   = res_exp_q;
    res_neg_d   = res_neg_q;
    if (pop) begin
      if (item_i.last) begin
        coeff_d     = '0;
        exp_d       = '0;
        cnt_d       = '0;
        point_d     = 1'b0;
        neg_d       = 1'b0;
        out_valid_d = 1'b1;
        res_mag_d   = coeff_n;
        res_exp_d   = exp_n;
        res_neg_d   = neg_n;
      end else begin
        coeff_d = coeff_n;
        exp_d   = exp_n;
        cnt_d   = cnt_n;
        point_d = point_n;
        neg_d   = neg_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q     <= '0;
      exp_q       <= '0;
      cnt_q       <= '0;
      point_q     <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      coeff_q     <= coeff_d;
      exp_q       <= exp_d;
      cnt_q       <= cnt_d;
      point_q     <= point_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_mag_q <= res_mag_d;
    res_exp_q <= res_exp_d;
    res_neg_q <= res_neg_d;
  end

  assign coef          = res_neg_q ? (CoeffW'(0) - res_mag_q) : res_mag_q;
  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef;
  assign exponent_o    = res_exp_q;
  assign packed_word_o = (res_exp_q == '0) ?
                         {TagInteger, {8{coef[CoeffW-1]}}, coef} :
                         {TagDecimal, res_exp_q, coef};

endmodule
